// File: rtl/core/pcm_channel_downmix_gain_assert.svh
// Assertion macros shared by the downmix and gain RTL.
`ifndef PCM_CHANNEL_DOWNMIX_GAIN_ASSERT_SVH
`define PCM_CHANNEL_DOWNMIX_GAIN_ASSERT_SVH

// Check a property on the rising clock edge, skipped while reset is held.
`define PDG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PDG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/pdg_pkg.sv
// Types and constants shared by the PCM downmix and gain block.
package pdg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int NUM_SLOTS  = 6;
    localparam int CNT_W      = 3;
    localparam int MIX_W      = 31;
    localparam int GAIN_W     = 16;
    localparam int PROD_W     = MIX_W + GAIN_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SHIFT_Q12  = 12;
    localparam int SHIFT_Q24  = 24;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h1000;
    localparam logic [GAIN_W-1:0] GAIN_ONE   = 16'd1;

    localparam logic signed [MIX_W-1:0] MIX_SIDE = 31'sd2896;

    localparam logic [CNT_W-1:0] CC_MONO     = 3'd1;
    localparam logic [CNT_W-1:0] CC_STEREO   = 3'd2;
    localparam logic [CNT_W-1:0] CC_SURROUND = 3'd6;

    localparam logic [1:0] SEL_PASS = 2'd0;
    localparam logic [1:0] SEL_LEFT = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEREO_SELECT  = 3'd0,
        CFG_DOWNMIX_ENABLE = 3'd1,
        CFG_GAIN_ENABLE    = 3'd2,
        CFG_MAIN_GAIN      = 3'd3,
        CFG_SURROUND_GAIN  = 3'd4
    } t_cfg_index;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic [1:0]        stereo_select;
        logic              downmix_enable;
        logic              gain_enable;
        logic [GAIN_W-1:0] main_gain;
        logic [GAIN_W-1:0] surround_gain;
    } t_cfg;

    typedef struct packed {
        logic signed [MIX_W-1:0] value;
        logic [GAIN_W-1:0]       gain;
        logic                    long_shift;
    } t_lane_op;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_stage_en;

endpackage

// File: rtl/core/pdg_route.sv
// Channel routing and 5.1 side-mix front end that sets up each lane's operands.
module pdg_route (
    input  pdg_pkg::t_cfg                  i_cfg,
    input  logic [pdg_pkg::CNT_W-1:0]      i_channel_count,
    input  pdg_pkg::t_sample               i_slot [pdg_pkg::NUM_SLOTS],
    output pdg_pkg::t_lane_op              o_op [pdg_pkg::NUM_SLOTS],
    output logic [pdg_pkg::CNT_W-1:0]      o_out_count,
    output logic                           o_supported
);

    // front*4096 + (rear + center + lfe)*2896
    function automatic logic signed [pdg_pkg::MIX_W-1:0] mix_side(
        input pdg_pkg::t_sample front,
        input pdg_pkg::t_sample rear,
        input pdg_pkg::t_sample center,
        input pdg_pkg::t_sample lfe
    );
        logic signed [pdg_pkg::SAMPLE_W+1:0] side;
        logic signed [pdg_pkg::MIX_W-1:0]    acc;
        side = 18'(rear) + 18'(center) + 18'(lfe);
        acc  = (pdg_pkg::MIX_W'(front) <<< pdg_pkg::SHIFT_Q12)
             + pdg_pkg::MIX_W'(side) * pdg_pkg::MIX_SIDE;
        return acc;
    endfunction

    logic [pdg_pkg::GAIN_W-1:0] main_sel;
    logic [pdg_pkg::GAIN_W-1:0] sur_sel;

    assign main_sel = i_cfg.gain_enable ? i_cfg.main_gain : pdg_pkg::GAIN_UNITY;
    assign sur_sel  = i_cfg.gain_enable ? i_cfg.surround_gain : pdg_pkg::GAIN_UNITY;

    always_comb begin
        for (int i = 0; i < pdg_pkg::NUM_SLOTS; i++) begin
            o_op[i].value      = '0;
            o_op[i].gain       = pdg_pkg::GAIN_UNITY;
            o_op[i].long_shift = 1'b0;
        end
        o_out_count = pdg_pkg::CC_STEREO;
        o_supported = 1'b0;

        unique case (i_channel_count)
            pdg_pkg::CC_MONO: begin
                o_supported   = 1'b1;
                o_op[0].value = pdg_pkg::MIX_W'(i_slot[0]);
                o_op[1].value = pdg_pkg::MIX_W'(i_slot[0]);
                o_op[0].gain  = main_sel;
                o_op[1].gain  = main_sel;
            end
            pdg_pkg::CC_STEREO: begin
                o_supported  = 1'b1;
                o_op[0].gain = main_sel;
                o_op[1].gain = main_sel;
                case (i_cfg.stereo_select)
                    pdg_pkg::SEL_PASS: begin
                        o_op[0].value = pdg_pkg::MIX_W'(i_slot[0]);
                        o_op[1].value = pdg_pkg::MIX_W'(i_slot[1]);
                    end
                    pdg_pkg::SEL_LEFT: begin
                        o_op[0].value = pdg_pkg::MIX_W'(i_slot[0]);
                        o_op[1].value = pdg_pkg::MIX_W'(i_slot[0]);
                    end
                    default: begin
                        o_op[0].value = pdg_pkg::MIX_W'(i_slot[1]);
                        o_op[1].value = pdg_pkg::MIX_W'(i_slot[1]);
                    end
                endcase
            end
            pdg_pkg::CC_SURROUND: begin
                o_supported = 1'b1;
                if (i_cfg.downmix_enable) begin
                    o_op[0].value = mix_side(i_slot[1], i_slot[3], i_slot[0], i_slot[5]);
                    o_op[1].value = mix_side(i_slot[2], i_slot[4], i_slot[0], i_slot[5]);
                    // with gain: sum*gain >> 24; without: sum*1 >> 12
                    for (int i = 0; i < 2; i++) begin
                        o_op[i].gain       = i_cfg.gain_enable ? i_cfg.surround_gain
                                                               : pdg_pkg::GAIN_ONE;
                        o_op[i].long_shift = i_cfg.gain_enable;
                    end
                end else begin
                    o_out_count   = pdg_pkg::CC_SURROUND;
                    o_op[0].value = pdg_pkg::MIX_W'(i_slot[1]);
                    o_op[1].value = pdg_pkg::MIX_W'(i_slot[2]);
                    o_op[2].value = pdg_pkg::MIX_W'(i_slot[0]);
                    o_op[3].value = pdg_pkg::MIX_W'(i_slot[5]);
                    o_op[4].value = pdg_pkg::MIX_W'(i_slot[3]);
                    o_op[5].value = pdg_pkg::MIX_W'(i_slot[4]);
                    for (int i = 0; i < pdg_pkg::NUM_SLOTS; i++) begin
                        o_op[i].gain = sur_sel;
                    end
                end
            end
            default: begin
                o_supported = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/pdg_lane.sv
// One sample lane: operand register, gain multiply, truncating scale and saturation.
module pdg_lane (
    input  logic                 i_clk,
    input  pdg_pkg::t_stage_en   i_en,
    input  pdg_pkg::t_lane_op    i_op,
    output pdg_pkg::t_sample     o_sample
);

    localparam logic signed [pdg_pkg::PROD_W-1:0] BIAS_Q12 =
        pdg_pkg::PROD_W'((1 << pdg_pkg::SHIFT_Q12) - 1);
    localparam logic signed [pdg_pkg::PROD_W-1:0] BIAS_Q24 =
        pdg_pkg::PROD_W'((1 << pdg_pkg::SHIFT_Q24) - 1);
    localparam logic signed [pdg_pkg::PROD_W-1:0] SAT_MAX = pdg_pkg::PROD_W'(32767);
    localparam logic signed [pdg_pkg::PROD_W-1:0] SAT_MIN = -pdg_pkg::PROD_W'(32768);

    pdg_pkg::t_lane_op                  r_op;
    logic signed [pdg_pkg::PROD_W-1:0]  r_prod;
    logic                               r_long;
    pdg_pkg::t_sample                   r_sample;
    pdg_pkg::t_sample                   n_sample;

    logic signed [pdg_pkg::PROD_W-1:0]  biased;
    logic signed [pdg_pkg::PROD_W-1:0]  shifted;

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_op <= i_op;
        end
        if (i_en.en2) begin
            r_prod <= $signed(r_op.value) * $signed({1'b0, r_op.gain});
            r_long <= r_op.long_shift;
        end
        if (i_en.en3) begin
            r_sample <= n_sample;
        end
    end

    // Round toward zero: bias negative products before the arithmetic shift.
    always_comb begin
        biased = r_prod;
        if (r_prod[pdg_pkg::PROD_W-1]) begin
            biased = r_prod + (r_long ? BIAS_Q24 : BIAS_Q12);
        end
        shifted = r_long ? (biased >>> pdg_pkg::SHIFT_Q24) : (biased >>> pdg_pkg::SHIFT_Q12);
        if (shifted > SAT_MAX) begin
            n_sample = SAT_MAX[pdg_pkg::SAMPLE_W-1:0];
        end else if (shifted < SAT_MIN) begin
            n_sample = SAT_MIN[pdg_pkg::SAMPLE_W-1:0];
        end else begin
            n_sample = shifted[pdg_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_sample = r_sample;

endmodule

// File: rtl/core/pcm_channel_downmix_gain.sv
// An input transaction reaches the output through the route, multiply and scale registers.
// Throughput: one frame per cycle unless stalled; a stage loads when the next is empty or moving.
// The output register holds a frame under backpressure while earlier stages keep filling.
// Frames with a channel count other than 1, 2 or 6 are taken and give no output.
// Synchronous active-low reset clears stage valids and loads the register defaults.
module pcm_channel_downmix_gain (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pdg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pdg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // in_slot_0 .. in_slot_5, 16 bits each, slot 0 lowest
    input  logic [pdg_pkg::NUM_SLOTS*pdg_pkg::SAMPLE_W-1:0] s_axis_tdata,
    // channel_count
    input  logic [pdg_pkg::CNT_W-1:0]         s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_slot_0 .. out_slot_5, 16 bits each, slot 0 lowest
    output logic [pdg_pkg::NUM_SLOTS*pdg_pkg::SAMPLE_W-1:0] m_axis_tdata,
    // out_channel_count
    output logic [pdg_pkg::CNT_W-1:0]         m_axis_tuser,
    output logic                              m_axis_tlast
);

`include "pcm_channel_downmix_gain_assert.svh"

    pdg_pkg::t_cfg      r_cfg;
    pdg_pkg::t_stage_en en;

    logic                          r_v1, r_v2, r_v3;
    logic [pdg_pkg::CNT_W-1:0]     r_cnt1, r_cnt2, r_cnt3;
    logic                          r_last1, r_last2, r_last3;

    pdg_pkg::t_sample              in_slot  [pdg_pkg::NUM_SLOTS];
    pdg_pkg::t_sample              lane_out [pdg_pkg::NUM_SLOTS];
    pdg_pkg::t_lane_op             lane_op  [pdg_pkg::NUM_SLOTS];
    logic [pdg_pkg::CNT_W-1:0]     out_count;
    logic                          supported;

    logic                          out_stereo;
    logic                          out_upper_zero;
    logic                          out_count_ok;
    logic                          in_dropped;
    logic                          pipe_empty;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stereo_select  <= pdg_pkg::SEL_PASS;
            r_cfg.downmix_enable <= 1'b1;
            r_cfg.gain_enable    <= 1'b0;
            r_cfg.main_gain      <= pdg_pkg::GAIN_UNITY;
            r_cfg.surround_gain  <= pdg_pkg::GAIN_UNITY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pdg_pkg::CFG_STEREO_SELECT:  r_cfg.stereo_select  <= i_cfg_data[1:0];
                pdg_pkg::CFG_DOWNMIX_ENABLE: r_cfg.downmix_enable <= i_cfg_data[0];
                pdg_pkg::CFG_GAIN_ENABLE:    r_cfg.gain_enable    <= i_cfg_data[0];
                pdg_pkg::CFG_MAIN_GAIN:
                    r_cfg.main_gain <= i_cfg_data[pdg_pkg::GAIN_W-1:0];
                pdg_pkg::CFG_SURROUND_GAIN:
                    r_cfg.surround_gain <= i_cfg_data[pdg_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Elastic stage enables: a stage loads when its successor is empty or advancing.
    assign en.en3        = !r_v3 || m_axis_tready;
    assign en.en2        = !r_v2 || en.en3;
    assign en.en1        = !r_v1 || en.en2;
    assign s_axis_tready = en.en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en.en1) r_v1 <= s_axis_tvalid && supported;
            if (en.en2) r_v2 <= r_v1;
            if (en.en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.en1) begin
            r_cnt1  <= out_count;
            r_last1 <= s_axis_tlast;
        end
        if (en.en2) begin
            r_cnt2  <= r_cnt1;
            r_last2 <= r_last1;
        end
        if (en.en3) begin
            r_cnt3  <= r_cnt2;
            r_last3 <= r_last2;
        end
    end

    always_comb begin
        for (int i = 0; i < pdg_pkg::NUM_SLOTS; i++) begin
            in_slot[i] = s_axis_tdata[i*pdg_pkg::SAMPLE_W +: pdg_pkg::SAMPLE_W];
        end
    end

    pdg_route u_route (
        .i_cfg           (r_cfg),
        .i_channel_count (s_axis_tuser),
        .i_slot          (in_slot),
        .o_op            (lane_op),
        .o_out_count     (out_count),
        .o_supported     (supported)
    );

    for (genvar g = 0; g < pdg_pkg::NUM_SLOTS; g++) begin : g_lane
        pdg_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_op     (lane_op[g]),
            .o_sample (lane_out[g])
        );
        assign m_axis_tdata[g*pdg_pkg::SAMPLE_W +: pdg_pkg::SAMPLE_W] = lane_out[g];
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tuser  = r_cnt3;
    assign m_axis_tlast  = r_last3;

    assign out_stereo     = m_axis_tvalid && (m_axis_tuser == pdg_pkg::CC_STEREO);
    assign out_upper_zero =
        (m_axis_tdata[pdg_pkg::NUM_SLOTS*pdg_pkg::SAMPLE_W-1:2*pdg_pkg::SAMPLE_W] == '0);
    assign out_count_ok   = (m_axis_tuser == pdg_pkg::CC_STEREO)
                         || (m_axis_tuser == pdg_pkg::CC_SURROUND);
    assign in_dropped     = s_axis_tvalid && s_axis_tready
                         && (s_axis_tuser != pdg_pkg::CC_MONO)
                         && (s_axis_tuser != pdg_pkg::CC_STEREO)
                         && (s_axis_tuser != pdg_pkg::CC_SURROUND);
    assign pipe_empty     = !r_v1 && !r_v2 && !r_v3;

    `PDG_ASSERT(a_stereo_pad_zero, i_clk, i_rst_n, out_stereo |-> out_upper_zero, "stereo pad set")
    `PDG_ASSERT(a_out_count, i_clk, i_rst_n, m_axis_tvalid |-> out_count_ok, "bad output count")
    `PDG_ASSERT(a_drop_unsupported, i_clk, i_rst_n, in_dropped |=> !r_v1, "unsupported frame kept")
    `PDG_ASSERT(a_stage2_hold, i_clk, i_rst_n, (r_v2 && !en.en2) |=> r_v2, "multiply stage lost frame")
    `PDG_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> pipe_empty, "pipe busy after reset")

endmodule

// File: bench/tb_pcm_channel_downmix_gain.sv
// Testbench for pcm_channel_downmix_gain: directed and random frames checked against a predictor.
module tb_pcm_channel_downmix_gain;

    localparam int CLK_PERIOD    = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LEN     = 300;
    localparam int RAND_PHASES   = 11;
    localparam int PHASE_FRAMES  = 50;

    localparam longint MIX_FRONT     = 4096;
    localparam longint MIX_SIDE_COEF = 2896;
    localparam longint Q12_ONE       = 4096;
    localparam longint Q24_ONE       = 16777216;
    localparam longint SAMPLE_MAX    = 32767;
    localparam longint SAMPLE_MIN    = -32768;

    localparam logic [2:0] CC_ZERO  = 3'd0;
    localparam logic [2:0] CC_THREE = 3'd3;
    localparam logic [2:0] CC_FOUR  = 3'd4;
    localparam logic [2:0] CC_FIVE  = 3'd5;
    localparam logic [2:0] CC_SEVEN = 3'd7;

    localparam logic [15:0] SEL_RIGHT     = 16'd2;
    localparam logic [15:0] SEL_ALT_RIGHT = 16'd3;

    localparam logic [2:0] CFG_SPARE_5 = 3'd5;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  cnt;
        logic [95:0] data;
        logic        last;
    } t_frame;

    typedef struct packed {
        logic [2:0]  cnt;
        logic [95:0] data;
        logic        last;
    } t_mix;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_index   = '0;
    logic [15:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    pdg_pkg::t_cfg mix_cfg;
    t_frame        frame_queue [$];
    t_mix          mix_expected [$];
    t_frame        on_bus;
    int unsigned   src_idle_pct = 25;
    int unsigned   snk_idle_pct = 61;
    logic          stall_kick   = 1'b0;
    int unsigned   stall_left   = 0;
    int            n_err        = 0;

    pcm_channel_downmix_gain dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int sat16(input longint v);
        if (v > SAMPLE_MAX) return int'(SAMPLE_MAX);
        if (v < SAMPLE_MIN) return int'(SAMPLE_MIN);
        return int'(v);
    endfunction

    function automatic int q12_gain(input int s, input logic [15:0] g);
        return sat16((longint'(s) * longint'({16'd0, g})) / Q12_ONE);
    endfunction

    function automatic int downmix_side(input int front, input int rear, input int ctr,
                                        input int lfe, input pdg_pkg::t_cfg c);
        longint acc;
        acc = longint'(front) * MIX_FRONT
            + (longint'(rear) + longint'(ctr) + longint'(lfe)) * MIX_SIDE_COEF;
        if (c.gain_enable) return sat16((acc * longint'({16'd0, c.surround_gain})) / Q24_ONE);
        return sat16(acc / MIX_FRONT);
    endfunction

    // Return 1 with the output frame in r, or 0 when the frame is dropped.
    function automatic logic mix_predict(input t_frame f, input pdg_pkg::t_cfg c,
                                         output t_mix r);
        int s [6];
        int o [6];
        int k;
        r = '0;
        r.cnt = pdg_pkg::CC_STEREO;
        r.last = f.last;
        for (k = 0; k < 6; k++) begin
            s[k] = int'($signed(f.data[16*k +: 16]));
            o[k] = 0;
        end
        case (f.cnt)
            pdg_pkg::CC_MONO: begin
                o[0] = s[0];
                o[1] = s[0];
                if (c.gain_enable) begin
                    o[0] = q12_gain(o[0], c.main_gain);
                    o[1] = q12_gain(o[1], c.main_gain);
                end
            end
            pdg_pkg::CC_STEREO: begin
                if (c.stereo_select == pdg_pkg::SEL_PASS) begin
                    o[0] = s[0];
                    o[1] = s[1];
                end else if (c.stereo_select == pdg_pkg::SEL_LEFT) begin
                    o[0] = s[0];
                    o[1] = s[0];
                end else begin
                    o[0] = s[1];
                    o[1] = s[1];
                end
                if (c.gain_enable) begin
                    o[0] = q12_gain(o[0], c.main_gain);
                    o[1] = q12_gain(o[1], c.main_gain);
                end
            end
            pdg_pkg::CC_SURROUND: begin
                if (c.downmix_enable) begin
                    o[0] = downmix_side(s[1], s[3], s[0], s[5], c);
                    o[1] = downmix_side(s[2], s[4], s[0], s[5], c);
                end else begin
                    r.cnt = pdg_pkg::CC_SURROUND;
                    o[0] = s[1];
                    o[1] = s[2];
                    o[2] = s[0];
                    o[3] = s[5];
                    o[4] = s[3];
                    o[5] = s[4];
                    if (c.gain_enable)
                        for (k = 0; k < 6; k++) o[k] = q12_gain(o[k], c.surround_gain);
                end
            end
            default: return 1'b0;
        endcase
        for (k = 0; k < 6; k++) r.data[16*k +: 16] = 16'(o[k]);
        return 1'b1;
    endfunction

    function automatic logic [95:0] slots6(input int a, input int b, input int c,
                                           input int d, input int e, input int f);
        return {16'(f), 16'(e), 16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return 16'($urandom_range(600)) - 16'd300;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return pdg_pkg::GAIN_UNITY;
            3:       return 16'($urandom_range(8192));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic add_frame(input logic [2:0] cnt, input logic [95:0] data, input logic last);
        t_frame f;
        f.cnt = cnt;
        f.data = data;
        f.last = last;
        frame_queue.push_back(f);
    endtask

    task automatic add_random_frame();
        logic [2:0]  cnt;
        logic [95:0] data;
        int k;
        if ($urandom_range(9) < 8) begin
            case ($urandom_range(2))
                0:       cnt = pdg_pkg::CC_MONO;
                1:       cnt = pdg_pkg::CC_STEREO;
                default: cnt = pdg_pkg::CC_SURROUND;
            endcase
        end else begin
            cnt = 3'($urandom_range(7));
        end
        for (k = 0; k < 6; k++) data[16*k +: 16] = pick_sample();
        add_frame(cnt, data, 1'($urandom_range(1)));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            pdg_pkg::CFG_STEREO_SELECT:  mix_cfg.stereo_select  = val[1:0];
            pdg_pkg::CFG_DOWNMIX_ENABLE: mix_cfg.downmix_enable = val[0];
            pdg_pkg::CFG_GAIN_ENABLE:    mix_cfg.gain_enable    = val[0];
            pdg_pkg::CFG_MAIN_GAIN:      mix_cfg.main_gain      = val;
            pdg_pkg::CFG_SURROUND_GAIN:  mix_cfg.surround_gain  = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_cfg(input logic [15:0] sel, input logic [15:0] dmx, input logic [15:0] gen,
                           input logic [15:0] mgain, input logic [15:0] sgain);
        write_reg(pdg_pkg::CFG_STEREO_SELECT, sel);
        write_reg(pdg_pkg::CFG_DOWNMIX_ENABLE, dmx);
        write_reg(pdg_pkg::CFG_GAIN_ENABLE, gen);
        write_reg(pdg_pkg::CFG_MAIN_GAIN, mgain);
        write_reg(pdg_pkg::CFG_SURROUND_GAIN, sgain);
    endtask

    // Wait for every queued frame to go in and every result to come out, then let dropped
    // frames flush through the pipeline.
    task automatic settle();
        do @(negedge i_clk);
        while (frame_queue.size() != 0 || s_axis_tvalid || mix_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic kick_stall();
        @(posedge i_clk);
        stall_kick <= 1'b1;
        @(posedge i_clk);
        stall_kick <= 1'b0;
    endtask

    always @(posedge i_clk) begin : drive_frames
        t_mix res;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (mix_predict(on_bus, mix_cfg, res)) mix_expected.push_back(res);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (frame_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    on_bus = frame_queue.pop_front();
                    s_axis_tdata  <= on_bus.data;
                    s_axis_tuser  <= on_bus.cnt;
                    s_axis_tlast  <= on_bus.last;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
        end else if (stall_kick) begin
            stall_left <= STALL_LEN;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_mix want;
        int k;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (mix_expected.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual cnt %0d data %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    n_err++;
                end else begin
                    want = mix_expected.pop_front();
                    if (m_axis_tuser !== want.cnt) begin
                        $display("%0t: channel count expected %0d actual %0d",
                                 $time, want.cnt, m_axis_tuser);
                        n_err++;
                    end
                    for (k = 0; k < 6; k++) begin
                        if (m_axis_tdata[16*k +: 16] !== want.data[16*k +: 16]) begin
                            $display("%0t: slot %0d expected %0d actual %0d", $time, k,
                                     $signed(want.data[16*k +: 16]),
                                     $signed(m_axis_tdata[16*k +: 16]));
                            n_err++;
                        end
                    end
                    if (m_axis_tlast !== want.last) begin
                        $display("%0t: block end expected %0b actual %0b",
                                 $time, want.last, m_axis_tlast);
                        n_err++;
                    end
                end
            end
            m_axis_tready <= (stall_left == 0) && !stall_kick
                             && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin : stimulus
        int p;
        int n;
        mix_cfg.stereo_select  = pdg_pkg::SEL_PASS;
        mix_cfg.downmix_enable = 1'b1;
        mix_cfg.gain_enable    = 1'b0;
        mix_cfg.main_gain      = pdg_pkg::GAIN_UNITY;
        mix_cfg.surround_gain  = pdg_pkg::GAIN_UNITY;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: extremes, downmix saturation, dropped channel counts.
        add_frame(pdg_pkg::CC_MONO, slots6(32767, 0, 0, 0, 0, 0), 1'b1);
        add_frame(pdg_pkg::CC_MONO, slots6(-32768, 1, 2, 3, 4, 5), 1'b0);
        add_frame(pdg_pkg::CC_STEREO, slots6(32767, -32768, 0, 0, 0, 0), 1'b1);
        add_frame(pdg_pkg::CC_SURROUND, {6{16'h7FFF}}, 1'b0);
        add_frame(pdg_pkg::CC_SURROUND, {6{16'h8000}}, 1'b1);
        add_frame(pdg_pkg::CC_SURROUND, slots6(100, -200, 300, -4000, 5000, -7), 1'b0);
        add_frame(CC_ZERO, {6{16'h7FFF}}, 1'b1);
        add_frame(CC_THREE, {6{16'h8000}}, 1'b0);
        add_frame(CC_FOUR, slots6(1, 2, 3, 4, 5, 6), 1'b1);
        add_frame(CC_FIVE, {6{16'hFFFF}}, 1'b0);
        add_frame(CC_SEVEN, '0, 1'b1);
        settle();

        // Stereo select three through a wide write; full and zero gains.
        set_cfg(16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'h0000);
        add_frame(pdg_pkg::CC_STEREO, slots6(1234, -32768, 0, 0, 0, 0), 1'b1);
        add_frame(pdg_pkg::CC_MONO, slots6(-1, 0, 0, 0, 0, 0), 1'b0);
        add_frame(pdg_pkg::CC_SURROUND, {6{16'h7FFF}}, 1'b1);
        settle();

        set_cfg(16'(pdg_pkg::SEL_LEFT), 16'd0, 16'd1, 16'h0000, 16'hFFFF);
        add_frame(pdg_pkg::CC_STEREO, slots6(32767, -5, 0, 0, 0, 0), 1'b0);
        add_frame(pdg_pkg::CC_SURROUND, slots6(32767, -32768, 1, -1, 32767, -32768), 1'b1);
        add_frame(pdg_pkg::CC_SURROUND, slots6(-1, 1, -2, 2, -3, 3), 1'b0);
        settle();

        write_reg(pdg_pkg::CFG_GAIN_ENABLE, 16'd0);
        write_reg(pdg_pkg::CFG_STEREO_SELECT, SEL_RIGHT);
        // Spare indexes must leave every register alone.
        write_reg(CFG_SPARE_5, 16'hFFFF);
        write_reg(CFG_SPARE_7, 16'h0001);
        add_frame(pdg_pkg::CC_STEREO, slots6(7, -9, 0, 0, 0, 0), 1'b1);
        add_frame(pdg_pkg::CC_SURROUND, slots6(-32768, 32767, -32768, 32767, -32768, 32767), 1'b0);
        settle();

        set_cfg(SEL_ALT_RIGHT, 16'd1, 16'd1, pdg_pkg::GAIN_ONE, pdg_pkg::GAIN_UNITY);
        add_frame(pdg_pkg::CC_SURROUND, slots6(-300, 12345, -23456, 777, -888, 5), 1'b1);
        add_frame(pdg_pkg::CC_MONO, slots6(32767, 0, 0, 0, 0, 0), 1'b0);
        add_frame(pdg_pkg::CC_STEREO, slots6(11, -32768, 0, 0, 0, 0), 1'b1);
        settle();

        for (p = 0; p < RAND_PHASES; p++) begin
            if (p == 4) begin
                src_idle_pct <= 61;
                snk_idle_pct <= 25;
            end
            if (p == 8) begin
                src_idle_pct <= 0;
                snk_idle_pct <= 0;
            end
            // Random upper bits exercise register masking.
            set_cfg(16'($urandom()), 16'($urandom()), 16'($urandom()), pick_gain(), pick_gain());
            for (n = 0; n < PHASE_FRAMES; n++) add_random_frame();
            if (p == 2 || p == 9) kick_stall();
            settle();
        end

        if (n_err == 0) begin
            $display("tb_pcm_channel_downmix_gain: done, clean");
        end else begin
            $display("tb_pcm_channel_downmix_gain: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * 400000);
        $display("tb_pcm_channel_downmix_gain: done, errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/pdg_pkg.sv
rtl/core/pdg_route.sv
rtl/core/pdg_lane.sv
rtl/core/pcm_channel_downmix_gain.sv
bench/tb_pcm_channel_downmix_gain.sv
